FILE: rtl/core/utf8dec_pkg.sv
// Package for the UTF-8 to UTF-16 line decoder.
// Holds the request/response payload types, the decode result struct and the
// lead-byte and surrogate constants. No dependencies.
package utf8dec_pkg;

   localparam int CpWidth   = 31;
   localparam int LineWidth = 32;

   localparam logic [7:0] LeadTwo   = 8'h80;
   localparam logic [7:0] LeadThree = 8'hE0;
   localparam logic [7:0] LeadFour  = 8'hF0;
   localparam logic [7:0] LeadFive  = 8'hF8;
   localparam logic [7:0] LeadSix   = 8'hFC;
   localparam logic [5:0] ContMask  = 6'h3F;

   localparam logic [CpWidth-1:0] NewlineCp = CpWidth'(8'h0A);
   localparam logic [CpWidth-1:0] PlaneOne  = CpWidth'(32'h0001_0000);
   localparam logic [15:0]        HighSurr  = 16'hD800;
   localparam logic [15:0]        LowSurr   = 16'hDC00;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [15:0]          code_unit;
      logic                 unit_valid;
      logic                 line_end;
      logic [LineWidth-1:0] line_number;
      logic                 last_of_run;
   } rsp_type;

   // Up to two responses caused by one request.
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } dec_out_type;

endpackage

FILE: rtl/core/utf8dec_decode.sv
// Sequence assembler and UTF-16 encoder of the line decoder.
// Holds the partial codepoint, pending byte count and line counter.
// Depends on utf8dec_pkg.
module utf8dec_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  utf8dec_pkg::req_type  req,
   output utf8dec_pkg::dec_out_type res
);
   import utf8dec_pkg::*;

   logic [CpWidth-1:0]   partial_ff, partial_in;
   logic [2:0]           remain_ff, remain_in;
   logic [LineWidth-1:0] lines_ff, lines_in;

   logic [CpWidth-1:0]   cp;
   logic [2:0]           remain_nx;
   logic                 complete;
   logic                 is_newline;
   logic                 is_pair;
   logic                 count_line;
   logic [LineWidth-1:0] lines_inc;
   logic [CpWidth-1:0]   base;
   logic [7:0]           b;

   assign b = req.data_byte;

   always_comb begin
      if (remain_ff != 3'd0) begin
         cp        = {partial_ff[CpWidth-7:0], b[5:0] & ContMask};
         remain_nx = remain_ff - 3'd1;
      end else if (b < LeadTwo) begin
         cp        = CpWidth'(b[6:0]);
         remain_nx = 3'd0;
      end else if (b < LeadThree) begin
         cp        = CpWidth'(b[4:0]);
         remain_nx = 3'd1;
      end else if (b < LeadFour) begin
         cp        = CpWidth'(b[3:0]);
         remain_nx = 3'd2;
      end else if (b < LeadFive) begin
         cp        = CpWidth'(b[2:0]);
         remain_nx = 3'd3;
      end else if (b < LeadSix) begin
         cp        = CpWidth'(b[1:0]);
         remain_nx = 3'd4;
      end else begin
         cp        = CpWidth'(b[0]);
         remain_nx = 3'd5;
      end
   end

   assign complete   = (remain_nx == 3'd0);
   assign is_newline = (cp == NewlineCp);
   assign is_pair    = !is_newline && (cp >= PlaneOne);
   assign count_line = complete && (is_newline || req.final_byte);
   assign lines_inc  = (lines_ff == '1) ? lines_ff : lines_ff + LineWidth'(1);
   assign lines_in   = count_line ? lines_inc : lines_ff;
   assign base       = cp - PlaneOne;

   always_comb begin
      if (complete || req.final_byte) begin
         partial_in = '0;
         remain_in  = 3'd0;
      end else begin
         partial_in = cp;
         remain_in  = remain_nx;
      end
   end

   always_comb begin
      res = '0;
      if (complete) begin
         if (is_newline) begin
            res.num                = 2'd1;
            res.first.line_end     = 1'b1;
            res.first.line_number  = lines_in;
            res.first.last_of_run  = 1'b1;
         end else if (!is_pair) begin
            res.num                = 2'd1;
            res.first.code_unit    = cp[15:0];
            res.first.unit_valid   = 1'b1;
            res.first.line_end     = req.final_byte;
            res.first.line_number  = lines_in;
            res.first.last_of_run  = 1'b1;
         end else begin
            res.num                = 2'd2;
            res.first.code_unit    = HighSurr | {6'd0, base[19:10]};
            res.first.unit_valid   = 1'b1;
            res.first.line_number  = lines_ff;
            res.second.code_unit   = LowSurr | {6'd0, base[9:0]};
            res.second.unit_valid  = 1'b1;
            res.second.line_end    = req.final_byte;
            res.second.line_number = lines_in;
            res.second.last_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= 3'd0;
         lines_ff   <= '0;
      end else if (accept) begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
         lines_ff   <= lines_in;
      end
   end

endmodule

FILE: rtl/core/utf8dec_outq.sv
// Four-entry response queue of the line decoder; takes up to two responses
// per cycle and hands out one while rsp_stall is low. Depends on utf8dec_pkg.
module utf8dec_outq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  utf8dec_pkg::dec_out_type  res,
   output logic                      full,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output utf8dec_pkg::rsp_type      rsp_data
);
   import utf8dec_pkg::*;

   rsp_type    mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] n_push;
   logic       pop;

   assign n_push    = push ? res.num : 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   // room for two more entries required before a request is taken
   assign full      = (count_ff > 3'd2);

   assign wr_ptr_in = wr_ptr_ff + n_push;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, n_push} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= res.first;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= res.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/utf8_to_utf16_line_decoder.sv
// UTF-8 to UTF-16 line decoder, top level. Takes one byte per request and
// returns UTF-16 units, newline markers and line counts. Uses utf8dec_pkg,
// utf8dec_decode and utf8dec_outq.
//
// A request is decoded in the cycle it is accepted and its responses are
// registered in a four-entry response queue that drives rsp_. One request
// can be accepted every cycle while the queue holds at most two entries; a
// request yields zero, one or two responses (two for a surrogate pair), and
// the queue drains one response per cycle while rsp_stall is low, so sustained
// throughput is one request per cycle unless pairs or rsp_stall back up the queue.
// Bytes of an incomplete sequence produce no response; a sequence cut short
// by the final byte is dropped. The line counter saturates at all ones.
module utf8_to_utf16_line_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  utf8dec_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output utf8dec_pkg::rsp_type rsp_data
);
   import utf8dec_pkg::*;

   dec_out_type res;
   logic        full;
   logic        accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   utf8dec_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .res    (res)
   );

   utf8dec_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .res       (res),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
